[design/crl_pkg.sv]
// Shared types and constants for the colour ramp lookup unit.
// No dependencies; imported by crl_search, crl_blend and the top level.
package crl_pkg;

  localparam int POS_W     = 17;  // input position, signed
  localparam int SPOS_W    = 16;  // stop position, unsigned
  localparam int COLOR_W   = 32;  // RGBA, 8 bits a channel
  localparam int CH_W      = 8;
  localparam int STOP_W    = SPOS_W + COLOR_W;
  localparam int STOP_REGS = 7;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = SPOS_W + CNT_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BASE  = 3'd1;

  localparam logic [CNT_W-1:0]  STOP_COUNT_RESET = 3'd2;
  localparam logic [STOP_W-1:0] STOP0_RESET      = 48'h0000_0000_00FF;
  localparam logic [STOP_W-1:0] STOP1_RESET      = 48'h8000_FFFF_FFFF;

  typedef logic [STOP_REGS-1:0][STOP_W-1:0] stop_array_t;

  // Beat handed from the stop search to the blend pipeline
  typedef struct packed {
    logic                 direct;   // colour_b goes out unchanged
    logic [CNT_W-1:0]     span;     // stop count less one
    logic [SPOS_W-1:0]    gap;      // found stop position minus input
    logic [COLOR_W-1:0]   color_a;  // previous stop colour
    logic [COLOR_W-1:0]   color_b;  // found stop colour
  } crl_sel_t;

endpackage

[design/crl_search.sv]
// Stop search: compare against every stop, then pick the stop pair.
// Two register stages. Depends on crl_pkg.
module crl_search #(
  parameter int MAX_STOPS              = 7,
  parameter int POSITION_FRACTION_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [crl_pkg::POS_W-1:0]     position,
  input  logic [crl_pkg::CNT_W-1:0]            stop_count,
  input  crl_pkg::stop_array_t                 stops,
  output logic                                 sel_valid,
  output crl_pkg::crl_sel_t                    sel
);
  import crl_pkg::*;

  localparam int ONE = 1 << POSITION_FRACTION_BITS;
  localparam int EPS = ONE / 10000;
  localparam logic signed [POS_W-1:0] ONE_POS = POS_W'(ONE);
  localparam logic [SPOS_W-1:0] EPS_GAP = SPOS_W'(EPS);

  // stage 1 registers
  logic                      s1_valid;
  logic signed [POS_W-1:0]   s1_pos;
  logic [CNT_W-1:0]          s1_n;
  logic [STOP_REGS-1:0]      s1_first;
  logic                      s1_none;
  logic                      s1_low;
  logic                      s1_high;

  logic [CNT_W-1:0]          n_eff;
  logic [STOP_REGS-1:0]      le;
  logic [STOP_REGS-1:0]      first;
  logic                      seen;

  always_comb begin
    priority if (stop_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (stop_count > CNT_W'(MAX_STOPS)) begin
      n_eff = CNT_W'(MAX_STOPS);
    end else begin
      n_eff = stop_count;
    end
  end

  always_comb begin
    seen = 1'b0;
    for (int k = 0; k < STOP_REGS; k++) begin
      le[k] = (CNT_W'(k) < n_eff) &&
              (position <= $signed({1'b0, stops[k][STOP_W-1:COLOR_W]}));
      first[k] = le[k] & ~seen;
      seen = seen | le[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_pos   <= position;
    s1_n     <= n_eff;
    s1_first <= first;
    s1_none  <= ~seen;
    s1_low   <= (n_eff == CNT_W'(1)) || (position <= $signed(POS_W'(0)));
    s1_high  <= position >= ONE_POS;
  end

  // stage 2: one-hot pick of the found stop and its predecessor
  logic [STOP_REGS-1:0]  last_oh;
  logic [STOP_REGS-1:0]  pick;
  logic [COLOR_W-1:0]    f_color;
  logic [COLOR_W-1:0]    p_color;
  logic [SPOS_W-1:0]     f_pos;
  logic [POS_W-1:0]      gap_full;
  crl_sel_t              sel_next;

  always_comb begin
    for (int k = 0; k < STOP_REGS; k++) begin
      last_oh[k] = (CNT_W'(k) == s1_n - CNT_W'(1));
    end
    priority if (s1_low) begin
      pick = STOP_REGS'(1);
    end else if (s1_high || s1_none) begin
      pick = last_oh;
    end else begin
      pick = s1_first;
    end
  end

  always_comb begin
    f_color = '0;
    f_pos   = '0;
    p_color = '0;
    for (int k = 0; k < STOP_REGS; k++) begin
      if (pick[k]) begin
        f_color = f_color | stops[k][COLOR_W-1:0];
        f_pos   = f_pos | stops[k][STOP_W-1:COLOR_W];
      end
    end
    for (int k = 0; k < STOP_REGS - 1; k++) begin
      if (pick[k+1]) begin
        p_color = p_color | stops[k][COLOR_W-1:0];
      end
    end
  end

  always_comb begin
    gap_full         = {1'b0, f_pos} - s1_pos;
    sel_next.gap     = gap_full[SPOS_W-1:0];
    sel_next.span    = s1_n - CNT_W'(1);
    sel_next.color_a = p_color;
    sel_next.color_b = f_color;
    sel_next.direct  = s1_low || s1_high || s1_none || s1_first[0] ||
                       (gap_full[SPOS_W-1:0] <= EPS_GAP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else begin
      sel_valid <= s1_valid;
    end
    sel <= sel_next;
  end

endmodule

[design/crl_blend.sv]
// Blend pipeline: fraction from the gap, then per-channel mix and rounding.
// Two register stages. Depends on crl_pkg.
module crl_blend #(
  parameter int POSITION_FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sel_valid,
  input  crl_pkg::crl_sel_t             sel,
  output logic                          done,
  output logic [crl_pkg::COLOR_W-1:0]   color
);
  import crl_pkg::*;

  localparam int PFB    = POSITION_FRACTION_BITS;
  localparam int ONE    = 1 << PFB;
  localparam int FRAC_W = PFB + 1;
  localparam int ACC_W  = PFB + CH_W + 1;
  localparam logic [FRAC_W-1:0] ONE_F   = FRAC_W'(ONE);
  localparam logic [PROD_W-1:0] ONE_P   = PROD_W'(ONE);
  localparam logic [ACC_W-1:0]  HALF    = ACC_W'(ONE >> 1);

  // stage 3: fraction = 1 - gap*(count-1), clamped at 0
  logic                  b_valid;
  logic                  b_direct;
  logic [COLOR_W-1:0]    b_ca;
  logic [COLOR_W-1:0]    b_cb;
  logic [FRAC_W-1:0]     b_frac;
  logic [PROD_W-1:0]     prod;
  logic [FRAC_W-1:0]     frac_next;

  always_comb begin
    prod = PROD_W'(sel.gap) * PROD_W'(sel.span);
    if (prod >= ONE_P) begin
      frac_next = '0;
    end else begin
      frac_next = ONE_F - prod[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= sel_valid;
    end
    b_direct <= sel.direct;
    b_ca     <= sel.color_a;
    b_cb     <= sel.color_b;
    b_frac   <= frac_next;
  end

  // stage 4: mix each channel, round half up
  logic [FRAC_W-1:0]   inv;
  logic [ACC_W-1:0]    acc [4];
  logic [COLOR_W-1:0]  mixed;

  always_comb begin
    inv = ONE_F - b_frac;
    for (int c = 0; c < 4; c++) begin
      acc[c] = ACC_W'(b_ca[CH_W*(3-c) +: CH_W]) * ACC_W'(inv) +
               ACC_W'(b_cb[CH_W*(3-c) +: CH_W]) * ACC_W'(b_frac) + HALF;
      mixed[CH_W*(3-c) +: CH_W] = acc[c][PFB+CH_W-1:PFB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid;
    end
    color <= b_direct ? b_cb : mixed;
  end

endmodule

[design/color_ramp_lookup_unit.sv]
// Top level of the colour ramp lookup unit: configuration registers and
// the four-stage lookup pipeline. Depends on crl_pkg, crl_search, crl_blend.
//
// One position is taken on every clock at which start is high (busy stays
// low), and its RGBA colour appears at the end of the four register
// stages with done high for a single cycle; the receiver cannot stall, so
// each result must be taken as it comes. The four register stages are:
// stop compare, stop pair selection, blend fraction, channel mix. Stop
// registers are written through wr_en/wr_index/wr_data and should only
// change while no lookup is in flight.
module color_ramp_lookup_unit #(
  parameter int MAX_STOPS              = 7,
  parameter int POSITION_FRACTION_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [crl_pkg::POS_W-1:0]    position,
  input  logic                                wr_en,
  input  logic [crl_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [crl_pkg::STOP_W-1:0]          wr_data,
  output logic                                done,
  output logic [crl_pkg::CH_W-1:0]            red,
  output logic [crl_pkg::CH_W-1:0]            green,
  output logic [crl_pkg::CH_W-1:0]            blue,
  output logic [crl_pkg::CH_W-1:0]            opacity
);
  import crl_pkg::*;

  logic [CNT_W-1:0]    stop_count;
  stop_array_t         stops;
  logic                sel_valid;
  crl_sel_t            sel;
  logic [COLOR_W-1:0]  color;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= STOP_COUNT_RESET;
      stops      <= {{((STOP_REGS-2)*STOP_W){1'b0}}, STOP1_RESET, STOP0_RESET};
    end else if (wr_en) begin
      if (wr_index == REG_STOP_COUNT) begin
        stop_count <= wr_data[CNT_W-1:0];
      end
      for (int k = 0; k < STOP_REGS; k++) begin
        if (wr_index == REG_STOP_BASE + CFG_IDX_W'(k)) begin
          stops[k] <= wr_data;
        end
      end
    end
  end

  crl_search #(
    .MAX_STOPS              (MAX_STOPS),
    .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .position   (position),
    .stop_count (stop_count),
    .stops      (stops),
    .sel_valid  (sel_valid),
    .sel        (sel)
  );

  crl_blend #(
    .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .sel_valid (sel_valid),
    .sel       (sel),
    .done      (done),
    .color     (color)
  );

  assign red     = color[31:24];
  assign green   = color[23:16];
  assign blue    = color[15:8];
  assign opacity = color[7:0];

endmodule

[design/crl_checker.sv]
// Port-level checks for the colour ramp lookup unit, bound to the top level.
// Depends only on the top level's ports.
module crl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every accepted beat gives a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted beat gave no result after four cycles");

  // no result without a matching accepted beat
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching accepted beat");

  // pipeline drains on reset
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result strobe high straight after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised on a fully pipelined unit");

endmodule

bind color_ramp_lookup_unit crl_checker u_crl_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
